/* design/wsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_pkg
// Shared types, constants and the solve microprogram of the weighted 2D
// similarity fit.
// ----------------------------------------------------------------------------
package wsf_pkg;

  localparam int COORD_BITS = 16;
  localparam int WGT_BITS   = 8;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 40;
  localparam int ADDR_BITS  = 4;
  localparam int RAM_DEPTH  = 16;
  localparam int PC_BITS    = 6;

  typedef enum logic [3:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_SHL,
    OP_DIV,
    OP_TEST,
    OP_FIXA,
    OP_BR,
    OP_END
  } op_t;

  // scratch register addresses
  localparam logic [ADDR_BITS-1:0] R_W   = 4'd0;
  localparam logic [ADDR_BITS-1:0] R_SX  = 4'd1;
  localparam logic [ADDR_BITS-1:0] R_SY  = 4'd2;
  localparam logic [ADDR_BITS-1:0] R_TX  = 4'd3;
  localparam logic [ADDR_BITS-1:0] R_TY  = 4'd4;
  localparam logic [ADDR_BITS-1:0] R_Q   = 4'd5;
  localparam logic [ADDR_BITS-1:0] R_P   = 4'd6;
  localparam logic [ADDR_BITS-1:0] R_R   = 4'd7;
  localparam logic [ADDR_BITS-1:0] R_X2  = 4'd8;
  localparam logic [ADDR_BITS-1:0] R_D   = 4'd9;
  localparam logic [ADDR_BITS-1:0] R_C   = 4'd10;
  localparam logic [ADDR_BITS-1:0] R_DEN = 4'd11;
  localparam logic [ADDR_BITS-1:0] R_T0  = 4'd12;
  localparam logic [ADDR_BITS-1:0] R_T1  = 4'd13;

  // output slots for divide results
  localparam logic [ADDR_BITS-1:0] O_A  = 4'd0;
  localparam logic [ADDR_BITS-1:0] O_B  = 4'd1;
  localparam logic [ADDR_BITS-1:0] O_TX = 4'd2;
  localparam logic [ADDR_BITS-1:0] O_TY = 4'd3;

  localparam logic [2:0] LOAD_LAST = 3'd7;
  localparam logic [PC_BITS-1:0] DEG_PC = 6'd38;

  typedef struct packed {
    op_t                  op;
    logic [ADDR_BITS-1:0] dst;
    logic [ADDR_BITS-1:0] a;
    logic [ADDR_BITS-1:0] b;
  } instr_t;

  typedef struct packed {
    logic                 in_ready;
    logic                 load;
    logic [2:0]           load_idx;
    logic                 clear;
    logic                 exec;
    op_t                  op;
    logic [ADDR_BITS-1:0] dst;
    logic [ADDR_BITS-1:0] ra;
    logic [ADDR_BITS-1:0] rb;
    logic                 publish;
  } cmd_t;

  typedef struct packed {
    logic last_in;
    logic pipe_empty;
    logic out_free;
    logic done;
    logic degenerate;
  } stat_t;

  function automatic instr_t prog(input logic [PC_BITS-1:0] pc);
    instr_t i;
    unique case (pc)
      6'd0:  i = '{OP_MUL,  R_T0,  R_W,  R_Q};
      6'd1:  i = '{OP_MUL,  R_T1,  R_SX, R_SX};
      6'd2:  i = '{OP_SUB,  R_T0,  R_T0, R_T1};
      6'd3:  i = '{OP_MUL,  R_T1,  R_SY, R_SY};
      6'd4:  i = '{OP_SUB,  R_X2,  R_T0, R_T1};
      6'd5:  i = '{OP_MUL,  R_T0,  R_W,  R_P};
      6'd6:  i = '{OP_MUL,  R_T1,  R_SX, R_TX};
      6'd7:  i = '{OP_SUB,  R_T0,  R_T0, R_T1};
      6'd8:  i = '{OP_MUL,  R_T1,  R_SY, R_TY};
      6'd9:  i = '{OP_SUB,  R_D,   R_T0, R_T1};
      6'd10: i = '{OP_MUL,  R_T0,  R_W,  R_R};
      6'd11: i = '{OP_MUL,  R_T1,  R_SX, R_TY};
      6'd12: i = '{OP_SUB,  R_T0,  R_T0, R_T1};
      6'd13: i = '{OP_MUL,  R_T1,  R_SY, R_TX};
      6'd14: i = '{OP_ADD,  R_C,   R_T0, R_T1};
      6'd15: i = '{OP_TEST, R_T0,  R_X2, R_X2};
      6'd16: i = '{OP_BR,   R_T0,  R_T0, R_T0};
      6'd17: i = '{OP_SUB,  R_T0,  R_D,  R_X2};
      6'd18: i = '{OP_SHL,  R_T0,  R_T0, R_T0};
      6'd19: i = '{OP_DIV,  O_A,   R_T0, R_X2};
      6'd20: i = '{OP_SHL,  R_T0,  R_C,  R_C};
      6'd21: i = '{OP_DIV,  O_B,   R_T0, R_X2};
      6'd22: i = '{OP_MUL,  R_DEN, R_W,  R_X2};
      6'd23: i = '{OP_MUL,  R_T0,  R_TX, R_X2};
      6'd24: i = '{OP_MUL,  R_T1,  R_D,  R_SX};
      6'd25: i = '{OP_SUB,  R_T0,  R_T0, R_T1};
      6'd26: i = '{OP_MUL,  R_T1,  R_C,  R_SY};
      6'd27: i = '{OP_ADD,  R_T0,  R_T0, R_T1};
      6'd28: i = '{OP_SHL,  R_T0,  R_T0, R_T0};
      6'd29: i = '{OP_DIV,  O_TX,  R_T0, R_DEN};
      6'd30: i = '{OP_MUL,  R_T0,  R_TY, R_X2};
      6'd31: i = '{OP_MUL,  R_T1,  R_C,  R_SX};
      6'd32: i = '{OP_SUB,  R_T0,  R_T0, R_T1};
      6'd33: i = '{OP_MUL,  R_T1,  R_D,  R_SY};
      6'd34: i = '{OP_SUB,  R_T0,  R_T0, R_T1};
      6'd35: i = '{OP_SHL,  R_T0,  R_T0, R_T0};
      6'd36: i = '{OP_DIV,  O_TY,  R_T0, R_DEN};
      6'd38: i = '{OP_FIXA, R_T0,  R_T0, R_T0};
      6'd39: i = '{OP_SHL,  R_T0,  R_TX, R_TX};
      6'd40: i = '{OP_DIV,  O_TX,  R_T0, R_W};
      6'd41: i = '{OP_SHL,  R_T0,  R_TY, R_TY};
      6'd42: i = '{OP_DIV,  O_TY,  R_T0, R_W};
      default: i = '{OP_END, R_T0, R_T0, R_T0};
    endcase
    return i;
  endfunction

endpackage

/* design/wsf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module wsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* design/wsf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_div
// Restoring divider, one quotient bit per cycle, truncation toward zero
// and saturation to the output width.
// ----------------------------------------------------------------------------
module wsf_div
  import wsf_pkg::*;
#(
  parameter int WIDE = 145
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [WIDE-1:0]     num,
  input  logic signed [WIDE-1:0]     den,
  output logic                       done,
  output logic [OUT_BITS-1:0]        quo
);

  localparam int CB = $clog2(WIDE);

  logic            busy;
  logic [CB-1:0]   cnt;
  logic [WIDE-1:0] nmag;
  logic [WIDE-1:0] dmag;
  logic [WIDE:0]   rem;
  logic [WIDE-1:0] q;
  logic            neg;
  logic            dzero;
  logic [WIDE:0]   rem_sh;
  logic            fits;
  logic            over_neg;
  logic            over_pos;

  assign rem_sh = {rem[WIDE-1:0], nmag[WIDE-1]};
  assign fits   = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        nmag  <= num[WIDE-1] ? WIDE'(-num) : num;
        dmag  <= den[WIDE-1] ? WIDE'(-den) : den;
        neg   <= num[WIDE-1] ^ den[WIDE-1];
        dzero <= den == '0;
        rem   <= '0;
        q     <= '0;
      end else if (busy) begin
        nmag <= {nmag[WIDE-2:0], 1'b0};
        rem  <= fits ? rem_sh - {1'b0, dmag} : rem_sh;
        q    <= {q[WIDE-2:0], fits};
        cnt  <= cnt + CB'(1);
        if (cnt == CB'(WIDE - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign over_neg = (|q[WIDE-1:OUT_BITS]) || (q[OUT_BITS-1] && (|q[OUT_BITS-2:0]));
  assign over_pos = |q[WIDE-1:OUT_BITS-1];

  always_comb begin
    if (dzero) begin
      quo = '0;
    end else if (neg) begin
      quo = over_neg ? {1'b1, {(OUT_BITS-1){1'b0}}} : OUT_BITS'(-q);
    end else begin
      quo = over_pos ? {1'b0, {(OUT_BITS-1){1'b1}}} : q[OUT_BITS-1:0];
    end
  end

endmodule

/* design/wsf_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_dpath
// Datapath: item pipeline into exact weighted sums, scratch RAM, serial
// multiplier, divider and the result register.
// ----------------------------------------------------------------------------
module wsf_dpath
  import wsf_pkg::*;
#(
  parameter int MAX_POINTS = 1024,
  parameter int WIDE       = 145
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic                          in_valid,
  input  logic [4*COORD_BITS+WGT_BITS-1:0] in_data,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4*OUT_BITS-1:0]         out_data,
  output logic                          out_deg
);

  localparam int C    = COORD_BITS;
  localparam int CNTB = $clog2(MAX_POINTS + 1);
  localparam int WB   = WGT_BITS + CNTB;
  localparam int PB   = 2 * C + 1;
  localparam int S1B  = C + WGT_BITS + 1 + CNTB;
  localparam int S2B  = PB + WGT_BITS + 1 + CNTB;
  localparam int MCB  = $clog2(WIDE);

  logic accept;
  logic [CNTB-1:0] cnt;

  logic                      p0_vld, p1_vld, p2_vld, p3_vld;
  logic signed [C-1:0]       x0, y0, u0, v0;
  logic [WGT_BITS-1:0]       w0, w1, w2, w3;
  logic signed [C-1:0]       x1, y1, u1, v1, x2, y2, u2, v2;
  logic signed [2*C-1:0]     xx1, yy1, xu1, yv1, xv1, yu1;
  logic signed [PB-1:0]      sq2, dot2, crs2;
  logic signed [C+WGT_BITS:0] wx3, wy3, wu3, wv3;
  logic signed [PB+WGT_BITS:0] wsq3, wdot3, wcrs3;

  logic [WB-1:0]          acc_w;
  logic signed [S1B-1:0]  acc_sx, acc_sy, acc_tx, acc_ty;
  logic signed [S2B-1:0]  acc_q, acc_p, acc_r;

  logic [WIDE-1:0]        rd_a, rd_b;
  logic signed [WIDE-1:0] ra_d, rb_d;
  logic                   we;
  logic [ADDR_BITS-1:0]   waddr;
  logic [WIDE-1:0]        wdata;
  logic [WIDE-1:0]        ld_data;

  logic                   mul_busy, mul_done;
  logic [MCB-1:0]         mul_cnt;
  logic [WIDE-1:0]        mul_mc, mul_mp, mul_acc;
  logic [ADDR_BITS-1:0]   mul_dst;

  logic                   div_start, div_done;
  logic [OUT_BITS-1:0]    div_quo;
  logic [ADDR_BITS-1:0]   div_dst;

  logic [OUT_BITS-1:0]    o_a, o_b, o_tx, o_ty;
  logic                   o_deg;

  assign accept = in_valid && cmd.in_ready;

  // item pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      p0_vld <= 1'b0;
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      p0_vld <= 1'b0;
      if (cmd.clear) begin
        cnt <= '0;
      end else if (accept && (cnt < CNTB'(MAX_POINTS))) begin
        p0_vld <= 1'b1;
        cnt    <= cnt + CNTB'(1);
      end
      p1_vld <= p0_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    x0 <= in_data[C-1:0];
    y0 <= in_data[2*C-1:C];
    u0 <= in_data[3*C-1:2*C];
    v0 <= in_data[4*C-1:3*C];
    w0 <= in_data[4*C+WGT_BITS-1:4*C];

    xx1 <= x0 * x0;
    yy1 <= y0 * y0;
    xu1 <= x0 * u0;
    yv1 <= y0 * v0;
    xv1 <= x0 * v0;
    yu1 <= y0 * u0;
    x1 <= x0; y1 <= y0; u1 <= u0; v1 <= v0; w1 <= w0;

    sq2  <= PB'(xx1) + PB'(yy1);
    dot2 <= PB'(xu1) + PB'(yv1);
    crs2 <= PB'(xv1) - PB'(yu1);
    x2 <= x1; y2 <= y1; u2 <= u1; v2 <= v1; w2 <= w1;

    wx3   <= $signed({1'b0, w2}) * x2;
    wy3   <= $signed({1'b0, w2}) * y2;
    wu3   <= $signed({1'b0, w2}) * u2;
    wv3   <= $signed({1'b0, w2}) * v2;
    wsq3  <= $signed({1'b0, w2}) * sq2;
    wdot3 <= $signed({1'b0, w2}) * dot2;
    wcrs3 <= $signed({1'b0, w2}) * crs2;
    w3    <= w2;
  end

  // weighted sums
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      acc_w  <= '0;
      acc_sx <= '0;
      acc_sy <= '0;
      acc_tx <= '0;
      acc_ty <= '0;
      acc_q  <= '0;
      acc_p  <= '0;
      acc_r  <= '0;
    end else if (p3_vld) begin
      acc_w  <= acc_w + WB'(w3);
      acc_sx <= acc_sx + S1B'(wx3);
      acc_sy <= acc_sy + S1B'(wy3);
      acc_tx <= acc_tx + S1B'(wu3);
      acc_ty <= acc_ty + S1B'(wv3);
      acc_q  <= acc_q + S2B'(wsq3);
      acc_p  <= acc_p + S2B'(wdot3);
      acc_r  <= acc_r + S2B'(wcrs3);
    end
  end

  always_comb begin
    case (cmd.load_idx)
      3'd0:    ld_data = WIDE'(acc_w);
      3'd1:    ld_data = WIDE'(acc_sx);
      3'd2:    ld_data = WIDE'(acc_sy);
      3'd3:    ld_data = WIDE'(acc_tx);
      3'd4:    ld_data = WIDE'(acc_ty);
      3'd5:    ld_data = WIDE'(acc_q);
      3'd6:    ld_data = WIDE'(acc_p);
      default: ld_data = WIDE'(acc_r);
    endcase
  end

  wsf_ram #(
    .WIDTH (WIDE),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (cmd.ra),
    .raddr_b (cmd.rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  assign ra_d = $signed(rd_a);
  assign rb_d = $signed(rd_b);

  always_comb begin
    we    = 1'b0;
    waddr = cmd.dst;
    wdata = mul_acc;
    if (cmd.load) begin
      we    = 1'b1;
      waddr = {1'b0, cmd.load_idx};
      wdata = ld_data;
    end else if (cmd.exec && (cmd.op == OP_ADD)) begin
      we    = 1'b1;
      wdata = ra_d + rb_d;
    end else if (cmd.exec && (cmd.op == OP_SUB)) begin
      we    = 1'b1;
      wdata = ra_d - rb_d;
    end else if (cmd.exec && (cmd.op == OP_SHL)) begin
      we    = 1'b1;
      wdata = ra_d <<< FRAC_BITS;
    end else if (mul_done) begin
      we    = 1'b1;
      waddr = mul_dst;
    end
  end

  // shift-add multiplier, product modulo 2^WIDE
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
      mul_cnt  <= '0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.exec && (cmd.op == OP_MUL)) begin
        mul_busy <= 1'b1;
        mul_cnt  <= '0;
        mul_mc   <= rd_a;
        mul_mp   <= rd_b;
        mul_acc  <= '0;
        mul_dst  <= cmd.dst;
      end else if (mul_busy) begin
        mul_acc <= mul_acc + (mul_mp[0] ? mul_mc : '0);
        mul_mc  <= {mul_mc[WIDE-2:0], 1'b0};
        mul_mp  <= {1'b0, mul_mp[WIDE-1:1]};
        mul_cnt <= mul_cnt + MCB'(1);
        if (mul_cnt == MCB'(WIDE - 1)) begin
          mul_busy <= 1'b0;
          mul_done <= 1'b1;
        end
      end
    end
  end

  assign div_start = cmd.exec && (cmd.op == OP_DIV);

  wsf_div #(
    .WIDE (WIDE)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ra_d),
    .den   (rb_d),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_dst <= cmd.dst;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (cmd.op == OP_TEST)) begin
      o_deg <= ra_d[WIDE-1] || (ra_d == '0);
    end
    if (cmd.exec && (cmd.op == OP_FIXA)) begin
      o_a <= {OUT_BITS{1'b1}} << FRAC_BITS;
      o_b <= '0;
    end
    if (div_done) begin
      case (div_dst)
        O_A:     o_a  <= div_quo;
        O_B:     o_b  <= div_quo;
        O_TX:    o_tx <= div_quo;
        default: o_ty <= div_quo;
      endcase
    end
  end

  assign out_data = {o_ty, o_tx, o_b, o_a};
  assign out_deg  = o_deg;

  assign stat.last_in    = accept && in_last;
  assign stat.pipe_empty = !(p0_vld || p1_vld || p2_vld || p3_vld);
  assign stat.out_free   = !out_valid;
  assign stat.done       = mul_done || div_done;
  assign stat.degenerate = o_deg;

endmodule

/* design/wsf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_ctrl
// Controller: item intake, drain, sum load and the solve microprogram.
// ----------------------------------------------------------------------------
module wsf_ctrl
  import wsf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_ACCUM,
    S_DRAIN,
    S_LOAD,
    S_READ,
    S_EXEC,
    S_WAIT,
    S_OUT
  } state_t;

  state_t             state;
  logic [PC_BITS-1:0] pc;
  logic [2:0]         idx;
  instr_t             ins;

  assign ins = prog(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACCUM;
      pc    <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_ACCUM: begin
          if (stat.last_in) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (stat.pipe_empty && stat.out_free) begin
            state <= S_LOAD;
            idx   <= '0;
          end
        end
        S_LOAD: begin
          idx <= idx + 3'd1;
          if (idx == LOAD_LAST) begin
            state <= S_READ;
            pc    <= '0;
          end
        end
        S_READ: begin
          unique case (ins.op)
            OP_BR:   pc <= stat.degenerate ? DEG_PC : pc + PC_BITS'(1);
            OP_END:  state <= S_OUT;
            default: state <= S_EXEC;
          endcase
        end
        S_EXEC: begin
          unique case (ins.op) inside
            OP_MUL, OP_DIV: state <= S_WAIT;
            default: begin
              pc    <= pc + PC_BITS'(1);
              state <= S_READ;
            end
          endcase
        end
        S_WAIT: begin
          if (stat.done) begin
            pc    <= pc + PC_BITS'(1);
            state <= S_READ;
          end
        end
        S_OUT: begin
          state <= S_ACCUM;
        end
        default: state <= S_ACCUM;
      endcase
    end
  end

  always_comb begin
    cmd.in_ready = state == S_ACCUM;
    cmd.load     = state == S_LOAD;
    cmd.load_idx = idx;
    cmd.clear    = (state == S_LOAD) && (idx == LOAD_LAST);
    cmd.exec     = state == S_EXEC;
    cmd.op       = ins.op;
    cmd.dst      = ins.dst;
    cmd.ra       = ins.a;
    cmd.rb       = ins.b;
    cmd.publish  = state == S_OUT;
  end

endmodule

/* design/weighted_similarity_fit_2d_top.sv */
`timescale 1ns / 1ps
// solve: after the item marked last, the sums are loaded and the solve runs on
//   the bit-serial multiplier and divider sharing the scratch RAM
//   (WIDE = 145 at MAX_POINTS = 1024)
// throughput: items stream in one per cycle until the last of a set; the next
//   set is taken once its result is in the output register
// reset: synchronous; clears the sums, the pair count and the output valid
// ----------------------------------------------------------------------------
// weighted_similarity_fit_2d_top
// Weighted 2D similarity fit: exact weighted sums per set, then a-1, b and
// the translation in Q.16 on the last item.
// ----------------------------------------------------------------------------
module weighted_similarity_fit_2d_top
  import wsf_pkg::*;
#(
  parameter int MAX_POINTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // src_x, src_y, dst_x, dst_y, weight
  input  logic [4*COORD_BITS+WGT_BITS-1:0] s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // scale_cos_minus_one, scale_sin, shift_x, shift_y
  output logic [4*OUT_BITS-1:0]            m_axis_tdata,
  // degenerate
  output logic [0:0]                       m_axis_tuser
);

  localparam int CNTB = $clog2(MAX_POINTS + 1);
  localparam int WIDE = 4 * COORD_BITS + 3 * (WGT_BITS + CNTB) + FRAC_BITS + 8;

  cmd_t  cmd;
  stat_t stat;

  wsf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  wsf_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .WIDE       (WIDE)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_deg   (m_axis_tuser[0])
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

/* design/wsf_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_check
// Port-level checks of the similarity fit, bound to the top level.
// ----------------------------------------------------------------------------
module wsf_check
  import wsf_pkg::*;
(
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [4*OUT_BITS-1:0]            m_axis_tdata,
  input logic [0:0]                       m_axis_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_last_stops_intake: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("item taken during solve");

  a_degenerate_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[2*OUT_BITS-1:OUT_BITS] == '0) &&
      (m_axis_tdata[OUT_BITS-1:0] == ({OUT_BITS{1'b1}} << FRAC_BITS)))
    else $error("degenerate result with nonzero rotation terms");

endmodule

bind weighted_similarity_fit_2d_top wsf_check u_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
